>>> hw/rtl/oaht_pkg.sv
// Package: shared constants, codes and structs of the hash table engine.
package oaht_pkg;

	localparam int SLOTS     = 256;
	localparam int SLOT_BITS = $clog2(SLOTS);
	localparam int KEY_W     = 32;
	localparam int VAL_W     = 64;
	localparam int OP_W      = 2;
	localparam int LIMIT_W   = 8;
	localparam int CNT_W     = 9;

	localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RST = 8'd179;

	localparam logic [OP_W-1:0] OP_GET = 2'd0;
	localparam logic [OP_W-1:0] OP_PUT = 2'd1;
	localparam logic [OP_W-1:0] OP_DEL = 2'd2;

	typedef enum logic [1:0] {
		MARK_EMPTY = 2'd0,
		MARK_LIVE  = 2'd1,
		MARK_TOMB  = 2'd2
	} mark_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                 rd_en;
		logic [SLOT_BITS-1:0] rd_addr;
		logic                 wr_key_en;
		logic                 wr_val_en;
		logic [SLOT_BITS-1:0] wr_addr;
		mark_t                wr_mark;
		logic [KEY_W-1:0]     wr_key;
		logic [VAL_W-1:0]     wr_value;
	} mem_req_t;

	typedef struct packed {
		mark_t            mark;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} mem_rsp_t;

	typedef struct packed {
		logic             found;
		logic             new_key;
		logic             table_full;
		logic [VAL_W-1:0] read_value;
	} res_t;

endpackage

>>> hw/rtl/open_address_hash_table_top.sv
// Top level: hash table engine with config register, probe sequencer, slot store, result register.
//
//   channel | direction | handshake          | beat
//   --------+-----------+--------------------+-------------------------------------------
//   in      | input     | in_valid/in_stall  | operation, key_id, key_hash, write_value
//   out     | output    | out_valid/out_stall| found, new_key, table_full, read_value
//   cfg     | input     | cfg_valid/cfg_ready| cfg_data (load_limit)
//
// Each operation probes 1 to 256 slots before the next one can be accepted, one slot per
// cycle through the key memory's read port.
// Reset clears every slot to empty at once through per-slot valid bits; no clearing pass.
// A result waits in the output register while the next beat is accepted; the sequencer holds
// its commit only when that register is still full and stalled.
module open_address_hash_table_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [oaht_pkg::OP_W-1:0]     operation,
	input  logic [oaht_pkg::KEY_W-1:0]    key_id,
	input  logic [oaht_pkg::KEY_W-1:0]    key_hash,
	input  logic [oaht_pkg::VAL_W-1:0]    write_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          found,
	output logic                          new_key,
	output logic                          table_full,
	output logic [oaht_pkg::VAL_W-1:0]    read_value,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [oaht_pkg::LIMIT_W-1:0]  cfg_data
);

	logic [oaht_pkg::LIMIT_W-1:0] load_limit_q;
	logic                         out_valid_q;
	oaht_pkg::res_t               out_q;
	oaht_pkg::res_t               res;
	oaht_pkg::mem_req_t           req;
	oaht_pkg::mem_rsp_t           rsp;
	logic                         push;
	logic                         out_free;

	// Config channel is always ready; the user must write only while idle, the block itself does not enforce it.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_limit_q <= oaht_pkg::LOAD_LIMIT_RST;
		end else if (cfg_valid) begin
			load_limit_q <= cfg_data;
		end
	end

	// Output register frees up when empty or when its beat leaves this cycle.
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold the payload while stalled; load a new beat on push.
	always_ff @(posedge clk) begin
		if (push) begin
			out_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign found      = out_q.found;
	assign new_key    = out_q.new_key;
	assign table_full = out_q.table_full;
	assign read_value = out_q.read_value;

	oaht_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.key_id      (key_id),
		.key_hash    (key_hash),
		.write_value (write_value),
		.load_limit  (load_limit_q),
		.out_free    (out_free),
		.push        (push),
		.res         (res),
		.req         (req),
		.rsp         (rsp)
	);

	oaht_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

>>> hw/rtl/oaht_store.sv
// Slot store: key/mark and value memories with registered reads and per-slot valid bits.
module oaht_store (
	input  logic               clk,
	input  logic               arst_n,
	input  oaht_pkg::mem_req_t req,
	output oaht_pkg::mem_rsp_t rsp
);

	logic [oaht_pkg::KEY_W-1:0] key_mem   [oaht_pkg::SLOTS];
	oaht_pkg::mark_t            mark_mem  [oaht_pkg::SLOTS];
	logic [oaht_pkg::VAL_W-1:0] value_mem [oaht_pkg::SLOTS];
	logic [oaht_pkg::SLOTS-1:0] valid_q;

	logic [oaht_pkg::KEY_W-1:0] key_rd_q;
	oaht_pkg::mark_t            mark_rd_q;
	logic [oaht_pkg::VAL_W-1:0] value_rd_q;
	logic                       valid_rd_q;

	always_ff @(posedge clk) begin
		if (req.wr_key_en) begin
			key_mem[req.wr_addr]  <= req.wr_key;
			mark_mem[req.wr_addr] <= req.wr_mark;
		end
		if (req.wr_val_en) begin
			value_mem[req.wr_addr] <= req.wr_value;
		end
		if (req.rd_en) begin
			key_rd_q   <= key_mem[req.rd_addr];
			mark_rd_q  <= mark_mem[req.rd_addr];
			value_rd_q <= value_mem[req.rd_addr];
		end
	end

	// A slot never written reads as empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			valid_rd_q <= 1'b0;
		end else begin
			if (req.wr_key_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				valid_rd_q <= valid_q[req.rd_addr];
			end
		end
	end

	always_comb begin
		rsp.mark  = valid_rd_q ? mark_rd_q : oaht_pkg::MARK_EMPTY;
		rsp.key   = key_rd_q;
		rsp.value = value_rd_q;
	end

endmodule

>>> hw/rtl/oaht_ctrl.sv
// Probe sequencer: walks slots one per cycle, decides the operation, commits the write.
module oaht_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [oaht_pkg::OP_W-1:0]     operation,
	input  logic [oaht_pkg::KEY_W-1:0]    key_id,
	input  logic [oaht_pkg::KEY_W-1:0]    key_hash,
	input  logic [oaht_pkg::VAL_W-1:0]    write_value,
	input  logic [oaht_pkg::LIMIT_W-1:0]  load_limit,
	input  logic                          out_free,
	output logic                          push,
	output oaht_pkg::res_t                res,
	output oaht_pkg::mem_req_t            req,
	input  oaht_pkg::mem_rsp_t            rsp
);

	oaht_pkg::state_t state_q, state_d;

	logic [oaht_pkg::OP_W-1:0]      op_q;
	logic [oaht_pkg::KEY_W-1:0]     key_q;
	logic [oaht_pkg::VAL_W-1:0]     wval_q;
	logic [oaht_pkg::SLOT_BITS-1:0] idx_q;
	logic [oaht_pkg::SLOT_BITS-1:0] n_q;
	logic                           have_tomb_q;
	logic [oaht_pkg::SLOT_BITS-1:0] tomb_idx_q;
	logic [oaht_pkg::CNT_W-1:0]     used_count_q;

	logic                           wr_key_en_q, wr_val_en_q, inc_q;
	logic [oaht_pkg::SLOT_BITS-1:0] wr_addr_q;
	oaht_pkg::mark_t                wr_mark_q;
	oaht_pkg::res_t                 res_q;

	logic                           cur_tomb, cur_empty, hit, stop, tomb_any, room;
	logic [oaht_pkg::SLOT_BITS-1:0] tomb_at;
	logic                           d_key_en, d_val_en, d_inc;
	logic [oaht_pkg::SLOT_BITS-1:0] d_addr;
	oaht_pkg::mark_t                d_mark;
	oaht_pkg::res_t                 d_res;

	// Probe decode of the slot read last cycle.
	always_comb begin
		cur_tomb  = (rsp.mark == oaht_pkg::MARK_TOMB);
		cur_empty = (rsp.mark == oaht_pkg::MARK_EMPTY);
		hit       = (rsp.mark == oaht_pkg::MARK_LIVE) && (rsp.key == key_q);
		stop      = hit || cur_empty || (&n_q) || (op_q != oaht_pkg::OP_GET &&
		            op_q != oaht_pkg::OP_PUT && op_q != oaht_pkg::OP_DEL);
		tomb_any  = have_tomb_q || cur_tomb;
		tomb_at   = have_tomb_q ? tomb_idx_q : idx_q;
		room      = used_count_q < {1'b0, load_limit};
	end

	always_comb begin
		d_key_en = 1'b0;
		d_val_en = 1'b0;
		d_inc    = 1'b0;
		d_addr   = idx_q;
		d_mark   = oaht_pkg::MARK_LIVE;
		d_res    = '0;
		case (op_q)
			oaht_pkg::OP_GET: begin
				d_res.found = hit;
				if (hit) begin
					d_res.read_value = rsp.value;
				end
			end
			oaht_pkg::OP_DEL: begin
				d_res.found = hit;
				d_key_en    = hit;
				d_mark      = oaht_pkg::MARK_TOMB;
			end
			oaht_pkg::OP_PUT: begin
				if (hit) begin
					d_res.found = 1'b1;
					d_key_en    = 1'b1;
					d_val_en    = 1'b1;
				end else if (tomb_any) begin
					d_res.new_key = 1'b1;
					d_key_en      = 1'b1;
					d_val_en      = 1'b1;
					d_addr        = tomb_at;
				end else if (cur_empty && room) begin
					d_res.new_key = 1'b1;
					d_key_en      = 1'b1;
					d_val_en      = 1'b1;
					d_inc         = 1'b1;
				end else begin
					d_res.table_full = 1'b1;
				end
			end
			default: begin
				d_res = '0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			oaht_pkg::ST_IDLE:  if (in_valid) state_d = oaht_pkg::ST_PROBE;
			oaht_pkg::ST_PROBE: if (stop) state_d = oaht_pkg::ST_DONE;
			oaht_pkg::ST_DONE:  if (out_free) state_d = oaht_pkg::ST_IDLE;
			default:            state_d = oaht_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall     = 1'b1;
		push         = 1'b0;
		req.rd_en    = 1'b0;
		req.rd_addr  = idx_q + {{(oaht_pkg::SLOT_BITS-1){1'b0}}, 1'b1};
		req.wr_key_en = 1'b0;
		req.wr_val_en = 1'b0;
		req.wr_addr  = wr_addr_q;
		req.wr_mark  = wr_mark_q;
		req.wr_key   = key_q;
		req.wr_value = wval_q;
		case (state_q)
			oaht_pkg::ST_IDLE: begin
				in_stall    = 1'b0;
				req.rd_en   = in_valid;
				req.rd_addr = key_hash[oaht_pkg::SLOT_BITS-1:0];
			end
			oaht_pkg::ST_PROBE: begin
				req.rd_en = !stop;
			end
			oaht_pkg::ST_DONE: begin
				push          = out_free;
				req.wr_key_en = out_free && wr_key_en_q;
				req.wr_val_en = out_free && wr_val_en_q;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
		res = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= oaht_pkg::ST_IDLE;
			used_count_q <= '0;
			have_tomb_q  <= 1'b0;
			wr_key_en_q  <= 1'b0;
			wr_val_en_q  <= 1'b0;
			inc_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				oaht_pkg::ST_IDLE: begin
					have_tomb_q <= 1'b0;
				end
				oaht_pkg::ST_PROBE: begin
					if (stop) begin
						wr_key_en_q <= d_key_en;
						wr_val_en_q <= d_val_en;
						inc_q       <= d_inc;
					end else if (cur_tomb && !have_tomb_q) begin
						have_tomb_q <= 1'b1;
					end
				end
				oaht_pkg::ST_DONE: begin
					if (out_free && inc_q) begin
						used_count_q <= used_count_q + {{(oaht_pkg::CNT_W-1){1'b0}}, 1'b1};
					end
				end
				default: begin
					have_tomb_q <= 1'b0;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == oaht_pkg::ST_IDLE && in_valid) begin
			op_q   <= operation;
			key_q  <= key_id;
			wval_q <= write_value;
			idx_q  <= key_hash[oaht_pkg::SLOT_BITS-1:0];
			n_q    <= '0;
		end else if (state_q == oaht_pkg::ST_PROBE) begin
			if (stop) begin
				wr_addr_q <= d_addr;
				wr_mark_q <= d_mark;
				res_q     <= d_res;
			end else begin
				if (cur_tomb && !have_tomb_q) begin
					tomb_idx_q <= idx_q;
				end
				idx_q <= idx_q + {{(oaht_pkg::SLOT_BITS-1){1'b0}}, 1'b1};
				n_q   <= n_q + {{(oaht_pkg::SLOT_BITS-1){1'b0}}, 1'b1};
			end
		end
	end

endmodule

>>> hw/rtl/oaht_checker.sv
// Checker: port-level assertions for the hash table engine, bound to the top level.
module oaht_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic                          found,
	input logic                          new_key,
	input logic                          table_full,
	input logic [oaht_pkg::VAL_W-1:0]    read_value
);

	// One operation in flight: an accepted beat closes the input for the next cycle.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted on back-to-back cycles");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_value) && $stable(found))
		else $error("stalled result changed");

	// A refused put reports nothing else.
	a_full_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && table_full |-> !found && !new_key && read_value == '0)
		else $error("table_full with other flags");

	// An inserted key was absent.
	a_new_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && new_key |-> !found)
		else $error("new_key together with found");

	// A nonzero value comes only from a hit.
	a_value_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_value != '0 |-> found)
		else $error("read_value without found");

endmodule

bind open_address_hash_table_top oaht_checker u_oaht_checker (.*);
